// ===== rtl/tlpjq_pkg.sv =====
// types and constants shared by the priority job queue
package tlpjq_pkg;

    localparam int TAG_W    = 16;
    localparam int CNT_W    = 16;
    localparam int CMD_W    = 2;
    localparam int PRIO_W   = 2;
    localparam int LEVEL_W  = 2;
    localparam int LEVELS   = 3;

    localparam logic [CNT_W-1:0] PENDING_MAX = {CNT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_POP     = 2'd1,
        CMD_DONE    = 2'd2,
        CMD_FLUSH   = 2'd3
    } cmd_t;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_HIGH       = 2'd0,
        LVL_NORMAL     = 2'd1,
        LVL_BACKGROUND = 2'd2,
        LVL_ALIAS      = 2'd3
    } level_t;

endpackage

// ===== rtl/three_level_priority_job_queue_top.sv =====
// three-level strict-priority job queue with a shared tag memory
//
// Every command (enqueue, pop, done, flush) is taken in the cycle that start is
// high; busy stays low, so a new command may follow in every cycle. Each
// command gives exactly one result beat, marked by result_valid, in the cycle
// after it is taken. The tag memory holds all three levels, and its single
// read port is registered, so a popped tag comes from the read register.
// The result is shown for one cycle only and the receiver cannot
// stall it. Queue pointers, fill counts and the pending counter sit in flops,
// so no clearing pass is needed after reset.
module three_level_priority_job_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tlpjq_pkg::CMD_W-1:0]   command,
    input  logic [tlpjq_pkg::PRIO_W-1:0]  priority_req,
    input  logic [tlpjq_pkg::TAG_W-1:0]   job_tag,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    output logic                          result_valid,
    output logic                          job_valid,
    output logic [tlpjq_pkg::TAG_W-1:0]   out_tag,
    output logic [tlpjq_pkg::LEVEL_W-1:0] out_level,
    output logic                          dropped,
    output logic [tlpjq_pkg::CNT_W-1:0]   pending_count,
    output logic                          queues_empty
);
    import tlpjq_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = LEVEL_W + PTR_W;
    localparam int MEM_D  = 1 << ADDR_W;
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    logic [TAG_W-1:0] mem [MEM_D];
    logic [TAG_W-1:0] rd_data_reg;

    logic             direct_run_reg;
    logic [PTR_W-1:0]  head_reg [LEVELS];
    logic [PTR_W-1:0]  head_next [LEVELS];
    logic [PTR_W-1:0]  tail_reg [LEVELS];
    logic [PTR_W-1:0]  tail_next [LEVELS];
    logic [FILL_W-1:0] fill_reg [LEVELS];
    logic [FILL_W-1:0] fill_next [LEVELS];
    logic [CNT_W-1:0]  pending_reg, pending_next;

    logic               res_valid_reg;
    logic               job_valid_reg, job_valid_next;
    logic               from_mem_reg, from_mem_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               dropped_reg, dropped_next;
    logic               empty_reg, empty_next;

    logic               accept;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [LEVEL_W-1:0] enq_level;
    logic [1:0]         enq_idx;
    cmd_t               cmd;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cmd       = cmd_t'(command);

    always_comb
    begin
        enq_level = (level_t'(priority_req) == LVL_ALIAS) ? LVL_NORMAL : priority_req;
        enq_idx   = enq_level;
        for (int i = 0; i < LEVELS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            fill_next[i] = fill_reg[i];
        end
        pending_next   = pending_reg;
        job_valid_next = 1'b0;
        from_mem_next  = 1'b0;
        tag_next       = '0;
        level_next     = '0;
        dropped_next   = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = {enq_level, tail_reg[enq_idx]};
        rd_addr        = '0;

        if (accept)
        begin
            unique case (cmd)
                CMD_ENQUEUE:
                begin
                    if (direct_run_reg)
                    begin
                        job_valid_next = 1'b1;
                        tag_next       = job_tag;
                        level_next     = enq_level;
                    end
                    else if (fill_reg[enq_idx] >= FILL_MAX)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        wr_en              = 1'b1;
                        tail_next[enq_idx] = (tail_reg[enq_idx] == PTR_LAST) ? '0
                                             : tail_reg[enq_idx] + 1'b1;
                        fill_next[enq_idx] = fill_reg[enq_idx] + 1'b1;
                        if (pending_reg != PENDING_MAX)
                        begin
                            pending_next = pending_reg + 1'b1;
                        end
                    end
                end
                CMD_POP:
                begin
                    for (int i = LEVELS - 1; i >= 0; i--)
                    begin
                        if (fill_reg[i] != '0)
                        begin
                            job_valid_next = 1'b1;
                            from_mem_next  = 1'b1;
                            level_next     = LEVEL_W'(i);
                            rd_addr        = {LEVEL_W'(i), head_reg[i]};
                        end
                    end
                    rd_en = from_mem_next;
                    for (int i = 0; i < LEVELS; i++)
                    begin
                        if (from_mem_next && level_next == LEVEL_W'(i))
                        begin
                            head_next[i] = (head_reg[i] == PTR_LAST) ? '0 : head_reg[i] + 1'b1;
                            fill_next[i] = fill_reg[i] - 1'b1;
                        end
                    end
                end
                CMD_DONE:
                begin
                    if (pending_reg != '0)
                    begin
                        pending_next = pending_reg - 1'b1;
                    end
                end
                CMD_FLUSH:
                begin
                    for (int i = 0; i < LEVELS; i++)
                    begin
                        head_next[i] = '0;
                        tail_next[i] = '0;
                        fill_next[i] = '0;
                    end
                    pending_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        empty_next = 1'b1;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (fill_next[i] != '0)
            begin
                empty_next = 1'b0;
            end
        end
    end

    // tag memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= job_tag;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_run_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            pending_reg   <= '0;
            res_valid_reg <= 1'b0;
            job_valid_reg <= 1'b0;
            from_mem_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
            empty_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                direct_run_reg <= cfg_data;
            end
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                fill_reg[i] <= fill_next[i];
            end
            pending_reg   <= pending_next;
            res_valid_reg <= accept;
            job_valid_reg <= job_valid_next;
            from_mem_reg  <= from_mem_next;
            dropped_reg   <= dropped_next;
            empty_reg     <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        level_reg <= level_next;
    end

    assign result_valid  = res_valid_reg;
    assign job_valid     = job_valid_reg;
    assign out_tag       = from_mem_reg ? rd_data_reg : tag_reg;
    assign out_level     = level_reg;
    assign dropped       = dropped_reg;
    assign pending_count = pending_reg;
    assign queues_empty  = empty_reg;

endmodule

// ===== rtl/tlpjq_checker.sv =====
// port-level checks for the priority job queue, bound to the top level
module tlpjq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [tlpjq_pkg::CMD_W-1:0]   command,
    input logic                          result_valid,
    input logic                          job_valid,
    input logic [tlpjq_pkg::TAG_W-1:0]   out_tag,
    input logic [tlpjq_pkg::LEVEL_W-1:0] out_level,
    input logic                          dropped,
    input logic [tlpjq_pkg::CNT_W-1:0]   pending_count,
    input logic                          queues_empty
);
    import tlpjq_pkg::*;

    // one result beat for each command, in the next cycle
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid == $past(start && !busy))
        else $error("result beat does not match an accepted command");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !job_valid) |-> (out_tag == '0 && out_level == '0))
        else $error("tag or level set without a job");

    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && dropped) |-> (!job_valid))
        else $error("dropped beat also hands out a job");

    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd_t'(command) == CMD_FLUSH)
        |=> (queues_empty && pending_count == '0))
        else $error("flush left state behind");

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && job_valid) |-> (level_t'(out_level) != LVL_ALIAS))
        else $error("job handed out from a level that does not exist");

endmodule

bind three_level_priority_job_queue_top tlpjq_checker u_tlpjq_checker (.*);

// ===== dv/three_level_priority_job_queue_top_tb.sv =====
// self-checking testbench for the three-level priority job queue
module three_level_priority_job_queue_top_tb;
    import tlpjq_pkg::*;

    localparam int          QUEUE_DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam int          PAIR_COUNT  = 16;

    typedef struct {
        cmd_t              cmd;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } job_req_t;

    typedef struct packed {
        logic             job_valid;
        logic [TAG_W-1:0] tag;
        level_t           level;
        logic             dropped;
        logic [CNT_W-1:0] pending;
        logic             empty;
    } job_result_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic [CMD_W-1:0]     command      = CMD_ENQUEUE;
    logic [PRIO_W-1:0]    priority_req = '0;
    logic [TAG_W-1:0]     job_tag      = '0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_data     = 1'b0;
    logic                 busy;
    logic                 cfg_ready;
    logic                 result_valid;
    logic                 job_valid;
    logic [TAG_W-1:0]     out_tag;
    logic [LEVEL_W-1:0]   out_level;
    logic                 dropped;
    logic [CNT_W-1:0]     pending_count;
    logic                 queues_empty;

    job_req_t             job_reqs[$];
    job_result_t          dispatch_results[$];

    logic                 beat_taken = 1'b0;
    int unsigned          burst_left = 1;
    int unsigned          gap_left   = 0;

    // predictor state
    logic                 run_direct = 1'b0;
    logic [TAG_W-1:0]     level_mem[LEVELS][QUEUE_DEPTH];
    int                   level_head[LEVELS];
    int                   level_tail[LEVELS];
    int                   level_fill[LEVELS];
    logic [CNT_W-1:0]     pending_jobs;

    int unsigned          n_pushed   = 0;
    int unsigned          n_accepted = 0;
    int unsigned          n_results  = 0;
    int unsigned          n_errors   = 0;
    int unsigned          n_handed   = 0;
    int unsigned          n_drops    = 0;
    int unsigned          n_at_max   = 0;
    int unsigned          n_mode_wr  = 0;
    int unsigned          cycle_count = 0;

    three_level_priority_job_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .priority_req  (priority_req),
        .job_tag       (job_tag),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .job_valid     (job_valid),
        .out_tag       (out_tag),
        .out_level     (out_level),
        .dropped       (dropped),
        .pending_count (pending_count),
        .queues_empty  (queues_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic job_result_t dispatch_predict(input job_req_t req);
        job_result_t r;
        level_t      lvl;
        bit          found;
        r     = '0;
        found = 1'b0;
        lvl   = (req.prio == LVL_ALIAS) ? LVL_NORMAL : level_t'(req.prio);
        case (req.cmd)
            CMD_ENQUEUE:
            begin
                if (run_direct)
                begin
                    r.job_valid = 1'b1;
                    r.tag       = req.tag;
                    r.level     = lvl;
                end
                else if (level_fill[lvl] >= QUEUE_DEPTH)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    level_mem[lvl][level_tail[lvl]] = req.tag;
                    level_tail[lvl] = (level_tail[lvl] + 1) % QUEUE_DEPTH;
                    level_fill[lvl]++;
                    if (pending_jobs != PENDING_MAX)
                        pending_jobs++;
                end
            end
            CMD_POP:
            begin
                for (int l = 0; l < LEVELS; l++)
                begin
                    if (!found && level_fill[l] != 0)
                    begin
                        found       = 1'b1;
                        r.job_valid = 1'b1;
                        r.tag       = level_mem[l][level_head[l]];
                        r.level     = level_t'(l);
                        level_head[l] = (level_head[l] + 1) % QUEUE_DEPTH;
                        level_fill[l]--;
                    end
                end
            end
            CMD_DONE:
            begin
                if (pending_jobs != '0)
                    pending_jobs--;
            end
            default:
            begin
                for (int l = 0; l < LEVELS; l++)
                begin
                    level_head[l] = 0;
                    level_tail[l] = 0;
                    level_fill[l] = 0;
                end
                pending_jobs = '0;
            end
        endcase
        r.pending = pending_jobs;
        r.empty   = (level_fill[0] == 0 && level_fill[1] == 0 && level_fill[2] == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // driver: one beat per accepted item, bursts separated by random gaps
    always @(negedge clk)
    begin
        if (beat_taken)
        begin
            job_reqs.delete(0);
            if (burst_left > 1)
                burst_left--;
            else
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                          : $urandom_range(1, 20);
                gap_left   = $urandom_range(0, 4);
            end
        end
        if (gap_left != 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (job_reqs.size() != 0)
        begin
            start        <= 1'b1;
            command      <= job_reqs[0].cmd;
            priority_req <= job_reqs[0].prio;
            job_tag      <= job_reqs[0].tag;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        job_req_t    req;
        job_result_t want;
        job_result_t got;
        if (rst_n)
        begin
            if (result_valid)
            begin
                n_results++;
                got = '{job_valid, out_tag, level_t'(out_level), dropped,
                        pending_count, queues_empty};
                if (dispatch_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result with nothing expected, got %0h", $time, got);
                end
                else
                begin
                    want = dispatch_results[0];
                    dispatch_results.delete(0);
                    check_field("job_valid", TAG_W'(want.job_valid), TAG_W'(got.job_valid));
                    check_field("out_tag", want.tag, got.tag);
                    check_field("out_level", TAG_W'(want.level), TAG_W'(got.level));
                    check_field("dropped", TAG_W'(want.dropped), TAG_W'(got.dropped));
                    check_field("pending_count", want.pending, got.pending);
                    check_field("queues_empty", TAG_W'(want.empty), TAG_W'(got.empty));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                run_direct = cfg_data;
                n_mode_wr++;
            end
            if (start && !busy)
            begin
                req  = '{cmd_t'(command), priority_req, job_tag};
                want = dispatch_predict(req);
                if (want.job_valid)
                    n_handed++;
                if (want.dropped)
                    n_drops++;
                if (want.pending == PENDING_MAX)
                    n_at_max++;
                dispatch_results.insert(dispatch_results.size(), want);
                n_accepted++;
            end
        end
        beat_taken <= rst_n && start && !busy;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_req(input cmd_t cmd, input logic [PRIO_W-1:0] prio,
                            input logic [TAG_W-1:0] tag);
        job_req_t req;
        req = '{cmd, prio, tag};
        job_reqs.insert(job_reqs.size(), req);
        n_pushed++;
    endtask

    task automatic add_random(input int count, input int enq_pct);
        int unsigned roll;
        int          pop_lim;
        pop_lim = enq_pct + (97 - enq_pct) * 3 / 4;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < enq_pct)
                push_req(CMD_ENQUEUE, PRIO_W'($urandom_range(0, 3)),
                         TAG_W'($urandom_range(0, 16'hffff)));
            else if (roll < pop_lim)
                push_req(CMD_POP, PRIO_W'($urandom_range(0, 3)),
                         TAG_W'($urandom_range(0, 16'hffff)));
            else if (roll < 97)
                push_req(CMD_DONE, PRIO_W'($urandom_range(0, 3)),
                         TAG_W'($urandom_range(0, 16'hffff)));
            else
                push_req(CMD_FLUSH, PRIO_W'($urandom_range(0, 3)),
                         TAG_W'($urandom_range(0, 16'hffff)));
        end
    endtask

    // wait until every accepted beat has produced its result
    task automatic settle;
        do
            @(negedge clk);
        while (n_accepted != n_pushed || n_results != n_accepted);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge clk);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            level_head[l] = 0;
            level_tail[l] = 0;
            level_fill[l] = 0;
        end
        pending_jobs = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // queued mode, directed
        write_mode(1'b0);
        push_req(CMD_POP, 2'd0, 16'h0000);
        push_req(CMD_DONE, 2'd3, 16'hffff);
        push_req(CMD_ENQUEUE, 2'd2, 16'ha5a5);
        push_req(CMD_ENQUEUE, 2'd1, 16'hffff);
        push_req(CMD_ENQUEUE, 2'd3, 16'h5a5a);
        push_req(CMD_ENQUEUE, 2'd0, 16'h0000);
        repeat (5) push_req(CMD_POP, 2'd0, 16'h0000);
        for (int i = 0; i < QUEUE_DEPTH + 1; i++)
            push_req(CMD_ENQUEUE, 2'd3, TAG_W'(16'h1000 + i));
        push_req(CMD_DONE, 2'd0, 16'h0000);
        push_req(CMD_FLUSH, 2'd2, 16'h0000);
        push_req(CMD_POP, 2'd0, 16'h0000);
        settle();

        // direct-run mode, directed
        write_mode(1'b1);
        push_req(CMD_ENQUEUE, 2'd0, 16'hffff);
        push_req(CMD_ENQUEUE, 2'd1, 16'h0000);
        push_req(CMD_ENQUEUE, 2'd2, 16'h1234);
        push_req(CMD_ENQUEUE, 2'd3, 16'h8001);
        push_req(CMD_POP, 2'd0, 16'h0000);
        push_req(CMD_DONE, 2'd0, 16'h0000);
        push_req(CMD_FLUSH, 2'd0, 16'h0000);
        settle();

        // random fill and drain sequences, with one run in direct-run mode
        write_mode(1'b0);
        for (int b = 0; b < 8; b++)
        begin
            case ($urandom_range(0, 2))
                0:       add_random(50, 80);
                1:       add_random(50, 50);
                default: add_random(50, 20);
            endcase
        end
        settle();
        write_mode(1'b1);
        add_random(100, 50);
        settle();
        write_mode(1'b0);
        add_random(60, 85);
        add_random(60, 15);
        settle();

        // alternating enqueue and pop run
        write_mode(1'b0);
        push_req(CMD_FLUSH, 2'd0, 16'h0000);
        for (int i = 0; i < PAIR_COUNT; i++)
        begin
            push_req(CMD_ENQUEUE, PRIO_W'($urandom_range(0, 3)),
                     TAG_W'($urandom_range(0, 16'hffff)));
            push_req(CMD_POP, PRIO_W'($urandom_range(0, 3)),
                     TAG_W'($urandom_range(0, 16'hffff)));
        end
        repeat (4) push_req(CMD_ENQUEUE, PRIO_W'($urandom_range(0, 3)),
                            TAG_W'($urandom_range(0, 16'hffff)));
        repeat (3) push_req(CMD_DONE, 2'd0, 16'h0000);
        push_req(CMD_POP, 2'd0, 16'h0000);
        push_req(CMD_FLUSH, 2'd0, 16'h0000);
        settle();

        repeat (4) @(posedge clk);
        n_errors += dispatch_results.size();
        $display("%0d commands checked over %0d mode writes: %0d jobs handed out,",
                 n_results, n_mode_wr, n_handed);
        $display("%0d enqueues dropped, %0d results with the pending counter at its ceiling",
                 n_drops, n_at_max);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== three_level_priority_job_queue_top.f =====
rtl/tlpjq_pkg.sv
rtl/three_level_priority_job_queue_top.sv
rtl/tlpjq_checker.sv
dv/three_level_priority_job_queue_top_tb.sv
